>>> rtl/sld_pkg.sv
// Package with the shared types, constants and the CRC byte function of the deframer.
`timescale 1ns / 1ps
`default_nettype none

package sld_pkg;

  localparam int unsigned MaxPayload  = 256;
  localparam int unsigned HeaderBytes = 13;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  localparam logic [7:0] SyncFirstReset  = 8'hA5;
  localparam logic [7:0] SyncSecondReset = 8'h5A;
  localparam logic [8:0] LimitReset      = 9'(MaxPayload & 32'h1FF);
  localparam logic [15:0] LimitCap       = 16'(MaxPayload);

  localparam logic [1:0] CfgSyncFirst    = 2'd0;
  localparam logic [1:0] CfgSyncSecond   = 2'd1;
  localparam logic [1:0] CfgPayloadLimit = 2'd2;

  localparam logic KindPayload  = 1'b0;
  localparam logic KindFrameEnd = 1'b1;

  localparam logic [1:0] StatusGood    = 2'd0;
  localparam logic [1:0] StatusTooLong = 2'd1;
  localparam logic [1:0] StatusCrcBad  = 2'd2;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_SYNC2  = 3'd1,
    PH_HEADER = 3'd2,
    PH_BODY   = 3'd3,
    PH_CRCLO  = 3'd4,
    PH_CRCHI  = 3'd5
  } phase_t;

  typedef struct packed {
    logic start;
    logic update;
  } crc_ctrl_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  frame_type;
    logic [15:0] body_length;
    logic [31:0] host_counter;
    logic [31:0] device_counter;
    logic [15:0] sequence_number;
    logic [1:0]  frame_status;
  } result_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/sof_length_crc16_deframer.sv
// Top level of the start-of-frame, length and CRC16 stream deframer.
//
//   channel | direction | handshake           | word
//   in_     | input     | in_valid / in_stall | data_byte
//   out_    | output    | out_valid/out_stall | result_kind and frame fields
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One byte is accepted per cycle unless stalled; out_valid marks its registered result.
// The byte CRC update between the input register and the CRC register sets the path.
// Reset puts the parser in the sync hunt, the CRC at FFFF and the config registers at defaults.
// A stalled result holds the output register; the input register then holds any
// byte it has and in_stall rises in the same cycle as out_stall blocks the output.
`timescale 1ns / 1ps
`default_nettype none

module sof_length_crc16_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_result_kind,
  output logic [7:0]       out_payload_byte,
  output logic [7:0]       out_frame_type,
  output logic [15:0]      out_body_length,
  output logic [31:0]      out_host_counter,
  output logic [31:0]      out_device_counter,
  output logic [15:0]      out_sequence_number,
  output logic [1:0]       out_frame_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [8:0]  cfg_data
);
  import sld_pkg::*;

  logic [7:0] sync_first_r, sync_first_nxt;
  logic [7:0] sync_second_r, sync_second_nxt;
  logic [8:0] limit_r, limit_nxt;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r, s1_byte_nxt;

  logic       out_valid_r, out_valid_nxt;
  result_t    out_r, out_nxt;

  logic       advance;
  logic       proc;
  logic [15:0] crc;
  crc_ctrl_t  crc_ctrl;
  logic       res_valid;
  result_t    res;

  assign cfg_ready = 1'b1;

  always_comb begin
    sync_first_nxt  = sync_first_r;
    sync_second_nxt = sync_second_r;
    limit_nxt       = limit_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CfgSyncFirst:    sync_first_nxt  = cfg_data[7:0];
        CfgSyncSecond:   sync_second_nxt = cfg_data[7:0];
        CfgPayloadLimit: limit_nxt       = cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = !out_valid_r || !out_stall;
  assign proc     = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  always_comb begin
    s1_valid_nxt = in_stall ? s1_valid_r : in_valid;
    s1_byte_nxt  = (in_valid && !in_stall) ? in_data_byte : s1_byte_r;
    out_valid_nxt = proc ? res_valid : (advance ? 1'b0 : out_valid_r);
    out_nxt       = (proc && res_valid) ? res : out_r;
  end

  sld_crc16 u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (crc_ctrl),
    .data  (s1_byte_r),
    .crc   (crc)
  );

  sld_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .proc          (proc),
    .data          (s1_byte_r),
    .sync_first    (sync_first_r),
    .sync_second   (sync_second_r),
    .payload_limit (limit_r),
    .crc           (crc),
    .crc_ctrl      (crc_ctrl),
    .res_valid     (res_valid),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= SyncFirstReset;
      sync_second_r <= SyncSecondReset;
      limit_r       <= LimitReset;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      sync_first_r  <= sync_first_nxt;
      sync_second_r <= sync_second_nxt;
      limit_r       <= limit_nxt;
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_byte_r <= s1_byte_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = out_r.kind;
  assign out_payload_byte    = out_r.payload_byte;
  assign out_frame_type      = out_r.frame_type;
  assign out_body_length     = out_r.body_length;
  assign out_host_counter    = out_r.host_counter;
  assign out_device_counter  = out_r.device_counter;
  assign out_sequence_number = out_r.sequence_number;
  assign out_frame_status    = out_r.frame_status;

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && out_stall))
    else $error("input stalled without a blocked output word");

  a_payload_status_good: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.kind == KindPayload) |-> (out_r.frame_status == StatusGood))
    else $error("payload word carries a nonzero status");

  a_no_result_lost: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> out_valid_r)
    else $error("stalled output word dropped");

endmodule

`default_nettype wire

>>> rtl/sld_crc16.sv
// Running CRC16-CCITT register, updated one byte per cycle when start or update is set.
`timescale 1ns / 1ps
`default_nettype none

module sld_crc16 (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sld_pkg::crc_ctrl_t ctrl,
  input  wire logic [7:0]        data,
  output logic [15:0]            crc
);
  import sld_pkg::*;

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;

  always_comb begin
    crc_nxt = crc_r;
    if (ctrl.start) begin
      crc_nxt = crc16_byte(CrcInit, data);
    end else if (ctrl.update) begin
      crc_nxt = crc16_byte(crc_r, data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CrcInit;
    end else begin
      crc_r <= crc_nxt;
    end
  end

  assign crc = crc_r;

endmodule

`default_nettype wire

>>> rtl/sld_parser.sv
// Frame state machine: sync hunt, header capture with length check, payload count and trailer check.
`timescale 1ns / 1ps
`default_nettype none

module sld_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               proc,
  input  wire logic [7:0]         data,
  input  wire logic [7:0]         sync_first,
  input  wire logic [7:0]         sync_second,
  input  wire logic [8:0]         payload_limit,
  input  wire logic [15:0]        crc,
  output sld_pkg::crc_ctrl_t      crc_ctrl,
  output logic                    res_valid,
  output sld_pkg::result_t        res
);
  import sld_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [8:0]  idx_r, idx_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] length_r, length_nxt;
  logic [31:0] host_r, host_nxt;
  logic [31:0] device_r, device_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [7:0]  crc_lo_r, crc_lo_nxt;

  logic [3:0]  hdr_idx;
  logic [8:0]  idx_inc;
  logic [15:0] limit_ext;
  logic [15:0] limit_eff;
  logic [15:0] length_full;

  assign hdr_idx     = idx_r[3:0];
  assign idx_inc     = idx_r + 9'd1;
  assign limit_ext   = {7'd0, payload_limit};
  assign limit_eff   = (limit_ext < LimitCap) ? limit_ext : LimitCap;
  assign length_full = {data, length_r[7:0]};

  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    type_nxt   = type_r;
    length_nxt = length_r;
    host_nxt   = host_r;
    device_nxt = device_r;
    seq_nxt    = seq_r;
    crc_lo_nxt = crc_lo_r;
    crc_ctrl   = '0;
    res_valid  = 1'b0;
    res.kind         = KindPayload;
    res.payload_byte = 8'd0;
    res.frame_status = StatusGood;

    if (proc) begin
      unique case (phase_r)
        PH_SYNC2: begin
          if (data == sync_second) begin
            crc_ctrl.update = 1'b1;
            phase_nxt = PH_HEADER;
            idx_nxt   = 9'd0;
          end else if (data == sync_first) begin
            crc_ctrl.start = 1'b1;
            phase_nxt  = PH_SYNC2;
            idx_nxt    = 9'd0;
            type_nxt   = 8'd0;
            length_nxt = 16'd0;
            host_nxt   = 32'd0;
            device_nxt = 32'd0;
            seq_nxt    = 16'd0;
            crc_lo_nxt = 8'd0;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_HEADER: begin
          crc_ctrl.update = 1'b1;
          case (hdr_idx) inside
            4'd0: type_nxt = data;
            4'd1: length_nxt[7:0] = data;
            4'd2: length_nxt[15:8] = data;
            [4'd3:4'd6]: host_nxt[8 * 2'(hdr_idx - 4'd3) +: 8] = data;
            [4'd7:4'd10]: device_nxt[8 * 2'(hdr_idx - 4'd7) +: 8] = data;
            [4'd11:4'd12]: seq_nxt[8 * 1'(hdr_idx - 4'd11) +: 8] = data;
            default: ;
          endcase
          if (hdr_idx == 4'd2 && length_full > limit_eff) begin
            res_valid        = 1'b1;
            res.kind         = KindFrameEnd;
            res.frame_status = StatusTooLong;
            phase_nxt = PH_HUNT;
            idx_nxt   = 9'd0;
          end else if (idx_inc >= 9'(HeaderBytes)) begin
            idx_nxt   = 9'd0;
            phase_nxt = (length_r == 16'd0) ? PH_CRCLO : PH_BODY;
          end else begin
            idx_nxt = idx_inc;
          end
        end
        PH_BODY: begin
          crc_ctrl.update  = 1'b1;
          res_valid        = 1'b1;
          res.kind         = KindPayload;
          res.payload_byte = data;
          if ({7'd0, idx_inc} >= length_r) begin
            idx_nxt   = 9'd0;
            phase_nxt = PH_CRCLO;
          end else begin
            idx_nxt = idx_inc;
          end
        end
        PH_CRCLO: begin
          crc_lo_nxt = data;
          phase_nxt  = PH_CRCHI;
        end
        PH_CRCHI: begin
          res_valid        = 1'b1;
          res.kind         = KindFrameEnd;
          res.frame_status = ({data, crc_lo_r} == crc) ? StatusGood : StatusCrcBad;
          phase_nxt = PH_HUNT;
          idx_nxt   = 9'd0;
        end
        default: begin
          if (data == sync_first) begin
            crc_ctrl.start = 1'b1;
            phase_nxt  = PH_SYNC2;
            idx_nxt    = 9'd0;
            type_nxt   = 8'd0;
            length_nxt = 16'd0;
            host_nxt   = 32'd0;
            device_nxt = 32'd0;
            seq_nxt    = 16'd0;
            crc_lo_nxt = 8'd0;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
      endcase
    end

    res.frame_type      = type_nxt;
    res.body_length     = length_nxt;
    res.host_counter    = host_nxt;
    res.device_counter  = device_nxt;
    res.sequence_number = seq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      idx_r    <= 9'd0;
      type_r   <= 8'd0;
      length_r <= 16'd0;
      host_r   <= 32'd0;
      device_r <= 32'd0;
      seq_r    <= 16'd0;
      crc_lo_r <= 8'd0;
    end else begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      type_r   <= type_nxt;
      length_r <= length_nxt;
      host_r   <= host_nxt;
      device_r <= device_nxt;
      seq_r    <= seq_nxt;
      crc_lo_r <= crc_lo_nxt;
    end
  end

  a_body_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_BODY) |-> ({7'd0, idx_r} < length_r))
    else $error("payload index reached the frame length inside the body");

  a_too_long_no_counters: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.frame_status == StatusTooLong) |->
      (res.host_counter == 32'd0 && res.sequence_number == 16'd0))
    else $error("length error carries counter fields");

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the start-of-frame, length and CRC16 stream deframer.
`timescale 1ns / 1ps

module testbench;
  import sld_pkg::*;

  class frame_checker;
    logic [7:0]  sync_a;
    logic [7:0]  sync_b;
    logic [8:0]  limit;
    phase_t      phase;
    logic [8:0]  pos;
    logic [15:0] crc;
    logic [7:0]  crc_lo;
    result_t     held;
    result_t     pending_results[$];
    int          failures;

    function new();
      sync_a   = SyncFirstReset;
      sync_b   = SyncSecondReset;
      limit    = LimitReset;
      phase    = PH_HUNT;
      pos      = '0;
      crc      = CrcInit;
      crc_lo   = '0;
      held     = '0;
      failures = 0;
    endfunction

    static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ b[i];
        c  = {c[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
      end
      return c;
    endfunction

    function logic [15:0] cap();
      return ({7'd0, limit} < LimitCap) ? {7'd0, limit} : LimitCap;
    endfunction

    function int outstanding();
      return pending_results.size();
    endfunction

    function void write_reg(logic [1:0] index, logic [8:0] value);
      case (index)
        CfgSyncFirst:    sync_a = value[7:0];
        CfgSyncSecond:   sync_b = value[7:0];
        CfgPayloadLimit: limit  = value;
        default: ;
      endcase
    endfunction

    function void open_frame(logic [7:0] b);
      phase  = PH_SYNC2;
      pos    = '0;
      crc    = crc_step(CrcInit, b);
      held   = '0;
      crc_lo = '0;
    endfunction

    function void emit(logic kind, logic [7:0] pb, logic [1:0] status);
      result_t r;
      r              = held;
      r.kind         = kind;
      r.payload_byte = pb;
      r.frame_status = status;
      pending_results.push_back(r);
    endfunction

    function void note_byte(logic [7:0] b);
      case (phase)
        PH_SYNC2: begin
          if (b == sync_b) begin
            crc   = crc_step(crc, b);
            phase = PH_HEADER;
            pos   = '0;
          end else if (b == sync_a) begin
            open_frame(b);
          end else begin
            phase = PH_HUNT;
          end
        end
        PH_HEADER: begin
          crc = crc_step(crc, b);
          if (pos == 0) held.frame_type = b;
          else if (pos <= 2) held.body_length[8*(pos-1) +: 8] = b;
          else if (pos <= 6) held.host_counter[8*(pos-3) +: 8] = b;
          else if (pos <= 10) held.device_counter[8*(pos-7) +: 8] = b;
          else held.sequence_number[8*(pos-11) +: 8] = b;
          if (pos == 2 && held.body_length > cap()) begin
            emit(KindFrameEnd, 8'h00, StatusTooLong);
            phase = PH_HUNT;
            pos   = '0;
            return;
          end
          pos = pos + 9'd1;
          if (pos >= HeaderBytes) begin
            pos   = '0;
            phase = (held.body_length == 0) ? PH_CRCLO : PH_BODY;
          end
        end
        PH_BODY: begin
          crc = crc_step(crc, b);
          emit(KindPayload, b, StatusGood);
          pos = pos + 9'd1;
          if ({7'd0, pos} >= held.body_length) begin
            pos   = '0;
            phase = PH_CRCLO;
          end
        end
        PH_CRCLO: begin
          crc_lo = b;
          phase  = PH_CRCHI;
        end
        PH_CRCHI: begin
          emit(KindFrameEnd, 8'h00, ({b, crc_lo} == crc) ? StatusGood : StatusCrcBad);
          phase = PH_HUNT;
          pos   = '0;
        end
        default: begin
          if (b == sync_a) open_frame(b);
          else phase = PH_HUNT;
        end
      endcase
    endfunction

    function void compare(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: kind %0h status %0h",
               got.kind, got.frame_status);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      compare("result_kind", want.kind, got.kind);
      compare("payload_byte", want.payload_byte, got.payload_byte);
      compare("frame_type", want.frame_type, got.frame_type);
      compare("body_length", want.body_length, got.body_length);
      compare("host_counter", want.host_counter, got.host_counter);
      compare("device_counter", want.device_counter, got.device_counter);
      compare("sequence_number", want.sequence_number, got.sequence_number);
      compare("frame_status", want.frame_status, got.frame_status);
    endfunction
  endclass

  localparam logic [1:0] CfgUnused   = 2'd3;
  localparam int         Settle      = 8;
  localparam int         LongHold    = 120;
  localparam int         RandomBytes = 220;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_stall    = 1'b0;
  logic        cfg_valid    = 1'b0;
  logic [1:0]  cfg_index    = CfgSyncFirst;
  logic [8:0]  cfg_data     = 9'd0;
  logic        in_stall;
  logic        out_valid;
  logic        out_result_kind;
  logic [7:0]  out_payload_byte;
  logic [7:0]  out_frame_type;
  logic [15:0] out_body_length;
  logic [31:0] out_host_counter;
  logic [31:0] out_device_counter;
  logic [15:0] out_sequence_number;
  logic [1:0]  out_frame_status;
  logic        cfg_ready;

  bit tx_gaps     = 1'b0;
  bit rx_stalls   = 1'b0;
  bit long_hold   = 1'b0;
  bit hold_active = 1'b0;
  int frame_bytes = 0;

  frame_checker frames;

  sof_length_crc16_deframer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_kind     (out_result_kind),
    .out_payload_byte    (out_payload_byte),
    .out_frame_type      (out_frame_type),
    .out_body_length     (out_body_length),
    .out_host_counter    (out_host_counter),
    .out_device_counter  (out_device_counter),
    .out_sequence_number (out_sequence_number),
    .out_frame_status    (out_frame_status),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      frames.check_result({out_result_kind, out_payload_byte, out_frame_type,
                           out_body_length, out_host_counter, out_device_counter,
                           out_sequence_number, out_frame_status});
    end
  end

  initial begin : receiver
    bit v;
    int n;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        v = 1'b1;
        n = LongHold;
        hold_active = 1'b1;
      end else if (rx_stalls && $urandom_range(0, 2) == 0) begin
        v = 1'b1;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      end else begin
        v = 1'b0;
        n = $urandom_range(1, 4);
      end
      out_stall <= v;
      repeat (n) @(posedge clk);
      if (hold_active) begin
        hold_active = 1'b0;
        long_hold   = 1'b0;
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("sof_length_crc16_deframer: mismatch");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    int n;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    frames.note_byte(b);
  endtask

  task automatic send_noise(input int n);
    for (int i = 0; i < n; i++) begin
      send_byte(($urandom_range(0, 5) == 0) ? frames.sync_a : 8'($urandom));
    end
  endtask

  task automatic send_frame(input logic [7:0] mtype, input logic [15:0] len,
                            input logic [31:0] host, input logic [31:0] dev,
                            input logic [15:0] seq, input bit bad_crc, input int cut);
    logic [7:0]  bytes[$];
    logic [15:0] crc;
    bytes = {frames.sync_a, frames.sync_b, mtype, len[7:0], len[15:8],
             host[7:0], host[15:8], host[23:16], host[31:24],
             dev[7:0], dev[15:8], dev[23:16], dev[31:24], seq[7:0], seq[15:8]};
    if (len <= frames.cap()) begin
      for (int i = 0; i < int'(len); i++) bytes.push_back(8'($urandom));
      crc = CrcInit;
      foreach (bytes[i]) crc = frames.crc_step(crc, bytes[i]);
      if (bad_crc) crc ^= 16'($urandom_range(1, 65535));
      bytes.push_back(crc[7:0]);
      bytes.push_back(crc[15:8]);
    end
    if (cut > 0 && cut < bytes.size()) bytes = bytes[0:cut-1];
    foreach (bytes[i]) send_byte(bytes[i]);
    frame_bytes += bytes.size();
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (frames.outstanding() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic configure(input logic [7:0] first, input logic [7:0] second,
                           input logic [8:0] lim);
    logic [1:0] idx[4];
    logic [8:0] val[4];
    wait_idle();
    idx = '{CfgUnused, CfgSyncFirst, CfgSyncSecond, CfgPayloadLimit};
    val = '{9'($urandom_range(0, 511)), {1'($urandom_range(0, 1)), first},
            {1'($urandom_range(0, 1)), second}, lim};
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      frames.write_reg(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] good_length();
    logic [15:0] c;
    c = frames.cap();
    if (c == 0) return 16'd0;
    if ($urandom_range(0, 24) == 0) return 16'($urandom_range(int'(c) / 2, int'(c)));
    return 16'($urandom_range(0, (c < 16) ? int'(c) : 16));
  endfunction

  function automatic logic [15:0] over_length();
    logic [15:0] c;
    c = frames.cap();
    if ($urandom_range(0, 2) == 0) return c + 16'd1;
    return 16'($urandom_range(int'(c) + 1, 65535));
  endfunction

  function automatic logic [8:0] pick_limit();
    case ($urandom_range(0, 5))
      0: return 9'd0;
      1: return 9'd256;
      2: return 9'd511;
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  initial begin : stimulus
    int next_cfg;
    int pick;
    frames = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(frames.sync_a);
    send_byte(8'h13);
    send_byte(frames.sync_a);
    send_frame(8'hFF, 16'd3, 32'hFFFF_FFFF, 32'h0000_0000, 16'h8001, 1'b0, 0);
    send_frame(8'h00, 16'd0, 32'h1234_5678, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, 0);
    send_frame(8'h5A, 16'd1, 32'h0BAD_F00D, 32'h0000_0001, 16'h0000, 1'b1, 0);
    send_frame(8'h01, 16'd257, 32'h1111_1111, 32'h2222_2222, 16'h3333, 1'b0, 0);
    send_frame(8'h02, 16'hFFFF, 32'h4444_4444, 32'h5555_5555, 16'h6666, 1'b0, 0);

    // The receiver holds off while a full-size frame keeps arriving.
    in_valid  <= 1'b0;
    long_hold = 1'b1;
    while (!hold_active) @(posedge clk);
    send_frame(8'h80, 16'd256, 32'hCAFE_0001, 32'h0000_FFFF, 16'h0102, 1'b0, 0);

    configure(8'h00, 8'hFF, 9'd0);
    send_frame(8'h11, 16'd0, 32'h0, 32'h0, 16'h0001, 1'b0, 0);
    send_frame(8'h12, 16'd1, 32'h0, 32'h0, 16'h0002, 1'b0, 0);
    configure(8'hFF, 8'h00, 9'd511);
    send_frame(8'h21, 16'd257, 32'h0, 32'h0, 16'h0003, 1'b0, 0);
    send_frame(8'h22, 16'd20, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 16'h0004, 1'b0, 0);
    configure(8'hA5, 8'hA5, 9'd1);
    send_frame(8'h31, 16'd1, 32'h0, 32'h0, 16'h0005, 1'b0, 0);
    send_frame(8'h32, 16'd2, 32'h0, 32'h0, 16'h0006, 1'b0, 0);

    frame_bytes = 0;
    next_cfg    = 0;
    while (frame_bytes < RandomBytes) begin
      if (frame_bytes >= next_cfg) begin
        next_cfg += 150;
        tx_gaps   = ($urandom_range(0, 2) != 0);
        rx_stalls = ($urandom_range(0, 2) != 0);
        configure(8'($urandom), 8'($urandom), pick_limit());
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_frame(8'($urandom), good_length(), $urandom, $urandom, 16'($urandom),
                   $urandom_range(0, 6) == 0, 0);
      end else if (pick < 75) begin
        send_frame(8'($urandom), over_length(), $urandom, $urandom, 16'($urandom),
                   1'b0, 0);
      end else if (pick < 87) begin
        send_noise($urandom_range(1, 8));
      end else begin
        send_frame(8'($urandom), good_length(), $urandom, $urandom, 16'($urandom),
                   1'b0, $urandom_range(1, 20));
      end
    end

    wait_idle();
    if (frames.failures == 0) begin
      $display("sof_length_crc16_deframer: match");
    end else begin
      $display("sof_length_crc16_deframer: mismatch");
    end
    $finish;
  end
endmodule
